// File: rtl/tts_pkg.sv
// ----------------------------------------------------------------------------
// tts_pkg: shared types and constants for the two-triangle slip-rate core
// config layout, queue item, divider request/response and sequencer states
// ----------------------------------------------------------------------------
`default_nettype none

package tts_pkg;

  localparam int unsigned MaxSamplesDef = 64;
  localparam int unsigned SampleBits    = 32;
  localparam int unsigned IterW         = 40;   // width of it0 / it1 / it2
  localparam int unsigned DivW          = 64;
  localparam int unsigned CfgIdxW       = 4;

  localparam logic [63:0] SampleLimit = (SampleBits >= 32) ? 64'h0000_0000_FFFF_FFFF
                                        : ((64'd1 << SampleBits) - 64'd1);

  localparam logic [31:0] RstDt   = 32'd655;
  localparam logic [6:0]  RstNt   = 7'd64;
  localparam logic [15:0] RstDmin = 16'd1024;
  localparam logic [15:0] RstDmax = 16'd1536;
  localparam logic [15:0] RstBd   = 16'd13107;
  localparam logic [15:0] RstBs   = 16'd32768;
  localparam logic [15:0] RstPf   = 16'd6554;
  localparam logic [16:0] RstRs   = 17'd0;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DT   = 4'd0,
    CFG_NT   = 4'd1,
    CFG_DMIN = 4'd2,
    CFG_DMAX = 4'd3,
    CFG_BD   = 4'd4,
    CFG_BS   = 4'd5,
    CFG_PF   = 4'd6,
    CFG_RS   = 4'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [31:0] dt;
    logic [6:0]  nt;
    logic [15:0] dmin;
    logic [15:0] dmax;
    logic [15:0] bd;
    logic [15:0] bs;
    logic [15:0] pf;
    logic [16:0] rs;
  } cfg_t;

  typedef enum logic [1:0] {
    CLS_DEEP,
    CLS_BAND,
    CLS_SHALLOW
  } cls_e;

  typedef struct packed {
    logic [31:0] slip;
    logic [31:0] rise;
    logic [15:0] depth;
    cls_e        cls;
  } req_t;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [DivW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            busy;
    logic [DivW-1:0] quot;
    logic [DivW-1:0] rem;
  } div_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CLASS,
    ST_BETA_R,
    ST_RT_R,
    ST_TR,
    ST_IT0,
    ST_IT0_R,
    ST_IT1_R,
    ST_IT2,
    ST_GEN,
    ST_GEN_R,
    ST_TRIM_INIT,
    ST_TRIM_RD,
    ST_TRIM_CHK,
    ST_TRIM_FIX,
    ST_SUM_RD,
    ST_SUM_ACC,
    ST_SUM_DONE,
    ST_F_RD,
    ST_F_SET,
    ST_F_R,
    ST_P,
    ST_Q_R,
    ST_EMIT,
    ST_DSTART,
    ST_DWAIT
  } st_e;

endpackage

`default_nettype wire

// File: rtl/tts_div.sv
// ----------------------------------------------------------------------------
// tts_div: shared restoring divider
// one quotient bit per cycle, quotient and remainder held after completion
// ----------------------------------------------------------------------------
`default_nettype none

module tts_div (
  input  wire                logic clk_i,
  input  wire                logic rst_ni,
  input  tts_pkg::div_req_t  req_i,
  output tts_pkg::div_rsp_t  rsp_o
);
  import tts_pkg::*;

  localparam int unsigned CntW = $clog2(DivW);

  logic            busy_q;
  logic [CntW-1:0] cnt_q;
  logic [DivW-1:0] quo_q, acc_q, dvs_q;
  logic [DivW:0]   shifted;
  logic            fits;

  assign shifted = {acc_q, quo_q[DivW-1]};
  assign fits    = shifted >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CntW'(DivW - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[DivW-2:0], fits};
      acc_q <= fits ? DivW'(shifted - {1'b0, dvs_q}) : DivW'(shifted);
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = acc_q;

endmodule

`default_nettype wire

// File: rtl/tts_front.sv
// ----------------------------------------------------------------------------
// tts_front: request intake
// classifies depth against the blend band and queues two requests
// ----------------------------------------------------------------------------
`default_nettype none

module tts_front (
  input  wire           logic clk_i,
  input  wire           logic rst_ni,
  input  tts_pkg::cfg_t cfg_i,
  input  wire           logic in_valid_i,
  output                logic in_ready_o,
  input  wire           logic [79:0] in_data_i,
  output                logic q_valid_o,
  output tts_pkg::req_t q_item_o,
  input  wire           logic q_pop_i
);
  import tts_pkg::*;

  req_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  req_t       item;
  logic       push, pop;

  always_comb begin
    item.slip  = in_data_i[31:0];
    item.rise  = in_data_i[63:32];
    item.depth = in_data_i[79:64];
    if (item.depth >= cfg_i.dmax) begin
      item.cls = CLS_DEEP;
    end else if (item.depth > cfg_i.dmin) begin
      item.cls = CLS_BAND;
    end else begin
      item.cls = CLS_SHALLOW;
    end
  end

  assign in_ready_o = cnt_q != 2'd2;
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = cnt_q != 2'd0;
  assign pop        = q_pop_i && q_valid_o;
  assign q_item_o   = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

// File: rtl/tts_back.sv
// ----------------------------------------------------------------------------
// tts_back: pulse sequencer
// builds the shape in a local buffer, trims, sums and scales it sample by sample
// ----------------------------------------------------------------------------
`default_nettype none

module tts_back #(
  parameter int unsigned MAX_SAMPLES = tts_pkg::MaxSamplesDef
) (
  input  wire               logic clk_i,
  input  wire               logic rst_ni,
  input  tts_pkg::cfg_t     cfg_i,
  input  wire               logic q_valid_i,
  input  tts_pkg::req_t     q_item_i,
  output                    logic q_pop_o,
  output tts_pkg::div_req_t div_req_o,
  input  tts_pkg::div_rsp_t div_rsp_i,
  output                    logic out_valid_o,
  input  wire               logic out_ready_i,
  output                    logic [31:0] out_value_o,
  output                    logic [5:0] out_index_o,
  output                    logic [6:0] out_len_o,
  output                    logic out_last_o
);
  import tts_pkg::*;

  localparam int unsigned AW = $clog2(MAX_SAMPLES);
  localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned IW = IterW;

  st_e state_q, state_d, ret_q;

  logic [31:0]   slip_q, rise_q;
  logic [15:0]   z_q, beta_q;
  cls_e          cls_q;
  logic [17:0]   rtfac_q;
  logic [33:0]   tr_q;
  logic [IW-1:0] it0_q, it1_q, it2_q;
  logic [CW-1:0] i_q, n_q, nt_q;
  logic [47:0]   s_q;
  logic [32:0]   f_q;
  logic [63:0]   dvd_q, dvs_q;
  logic [31:0]   rd_q;
  logic [31:0]   res_val_q;
  logic          res_last_q;

  logic [31:0] shape_mem [MAX_SAMPLES];
  logic          mem_we;
  logic [AW-1:0] mem_ra;
  logic [31:0]   mem_wd;

  logic          out_valid_q;
  logic [31:0]   out_value_q;
  logic [5:0]    out_index_q;
  logic [6:0]    out_len_q;
  logic          out_last_q;
  logic          can_load;

  // shared datapath terms
  logic [31:0]   dt_eff;
  logic [47:0]   den;
  logic [CW-1:0] nt_eff;
  logic [15:0]   dz_lo, dz_hi, w;
  logic [31:0]   p_bd, p_bs;
  logic [32:0]   p_rs;
  logic [33:0]   beta_num, rt_num;
  logic [49:0]   tr_prod, tr_sum;
  logic [49:0]   it0_prod;
  logic [51:0]   it0_num;
  logic [57:0]   it2_prod;
  logic [IW-1:0] iw, d_tail;
  logic          in_rise, in_fall, in_tail;
  logic [30:0]   b_tail;
  logic [CW-1:0] i_off;
  logic [30+CW:0] tail_prod;
  logic [64:0]   slip_prod;
  logic [63:0]   q_round, rem_up;
  logic [31:0]   v_gen;

  assign dt_eff   = (cfg_i.dt == 32'd0) ? 32'd1 : cfg_i.dt;
  assign den      = {dt_eff, 16'd0};
  assign nt_eff   = (cfg_i.nt > 7'(MAX_SAMPLES)) ? CW'(MAX_SAMPLES) : CW'(cfg_i.nt);
  assign dz_lo    = z_q - cfg_i.dmin;
  assign dz_hi    = cfg_i.dmax - z_q;
  assign w        = cfg_i.dmax - cfg_i.dmin;
  assign p_bd     = cfg_i.bd * dz_lo;
  assign p_bs     = cfg_i.bs * dz_hi;
  assign p_rs     = cfg_i.rs * dz_hi;
  assign beta_num = 34'(p_bd) + 34'(p_bs) + 34'(w >> 1);
  assign rt_num   = 34'(p_rs) + 34'(w >> 1);
  assign tr_prod  = rise_q * rtfac_q;
  assign tr_sum   = tr_prod + 50'd32768;
  assign it0_prod = cfg_i.pf * tr_q;
  assign it0_num  = {1'b0, it0_prod, 1'b0} + 52'(den);
  assign it2_prod = (18'd131072 - 18'(beta_q)) * it0_q;

  // shape segment of the current index
  assign iw      = IW'(i_q);
  assign in_rise = iw < it0_q;
  assign in_fall = iw < it2_q;
  assign in_tail = iw < it1_q;
  assign b_tail  = {beta_q, 15'd0};
  assign i_off   = CW'(iw - it2_q);
  assign d_tail  = it1_q - it2_q;
  assign tail_prod = b_tail * i_off;

  always_comb begin
    if (in_rise) begin
      v_gen = div_rsp_i.quot[31:0];
    end else if (in_fall) begin
      v_gen = 32'h8000_0000 - div_rsp_i.quot[31:0];
    end else begin
      v_gen = {1'b0, b_tail} - div_rsp_i.quot[31:0];
    end
  end

  // rounding of the scaled sample, half up
  assign slip_prod = slip_q * f_q;
  assign rem_up    = 64'(den) - div_rsp_i.rem;
  assign q_round   = (div_rsp_i.rem >= rem_up) ? div_rsp_i.quot + 64'd1 : div_rsp_i.quot;

  assign can_load = !out_valid_q || out_ready_i;

  always_comb begin
    state_d           = state_q;
    q_pop_o           = 1'b0;
    div_req_o.start   = 1'b0;
    div_req_o.dividend = dvd_q;
    div_req_o.divisor = dvs_q;
    mem_we            = 1'b0;
    mem_wd            = 32'd0;
    mem_ra            = AW'(i_q);
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          state_d = ST_CLASS;
        end
      end
      ST_CLASS: state_d = (cls_q == CLS_BAND) ? ST_DSTART : ST_TR;
      ST_BETA_R: state_d = ST_DSTART;
      ST_RT_R: state_d = ST_TR;
      ST_TR: state_d = ST_IT0;
      ST_IT0: state_d = ST_DSTART;
      ST_IT0_R: state_d = ST_DSTART;
      ST_IT1_R: state_d = ST_IT2;
      ST_IT2: state_d = ST_GEN;
      ST_GEN: begin
        if (i_q == nt_q) begin
          state_d = ST_TRIM_INIT;
        end else if (in_rise || in_fall || in_tail) begin
          state_d = ST_DSTART;
        end else begin
          mem_we = 1'b1;
        end
      end
      ST_GEN_R: begin
        mem_we  = 1'b1;
        mem_wd  = v_gen;
        state_d = ST_GEN;
      end
      ST_TRIM_INIT: state_d = ST_TRIM_RD;
      ST_TRIM_RD: begin
        mem_ra  = AW'(n_q);
        state_d = (n_q == '0) ? ST_TRIM_FIX : ST_TRIM_CHK;
      end
      ST_TRIM_CHK: state_d = (rd_q == 32'd0) ? ST_TRIM_RD : ST_TRIM_FIX;
      ST_TRIM_FIX: state_d = ST_SUM_RD;
      ST_SUM_RD: state_d = (i_q == n_q) ? ST_SUM_DONE : ST_SUM_ACC;
      ST_SUM_ACC: state_d = ST_SUM_RD;
      ST_SUM_DONE: state_d = (n_q == '0 || s_q == 48'd0) ? ST_EMIT : ST_F_RD;
      ST_F_RD: state_d = ST_F_SET;
      ST_F_SET: state_d = ST_DSTART;
      ST_F_R: state_d = ST_P;
      ST_P: state_d = ST_DSTART;
      ST_Q_R: state_d = ST_EMIT;
      ST_EMIT: begin
        if (can_load) begin
          state_d = res_last_q ? ST_IDLE : ST_F_RD;
        end
      end
      ST_DSTART: begin
        div_req_o.start = 1'b1;
        state_d         = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (!div_rsp_i.busy) begin
          state_d = ret_q;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      shape_mem[AW'(i_q)] <= mem_wd;
    end
    rd_q <= shape_mem[mem_ra];
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        slip_q <= q_item_i.slip;
        rise_q <= q_item_i.rise;
        z_q    <= q_item_i.depth;
        cls_q  <= q_item_i.cls;
      end
      ST_CLASS: begin
        case (cls_q)
          CLS_DEEP: begin
            beta_q  <= cfg_i.bd;
            rtfac_q <= 18'd65536;
          end
          CLS_SHALLOW: begin
            beta_q  <= cfg_i.bs;
            rtfac_q <= 18'd65536 + 18'(cfg_i.rs);
          end
          default: begin
            dvd_q <= 64'(beta_num);
            dvs_q <= 64'(w);
            ret_q <= ST_BETA_R;
          end
        endcase
      end
      ST_BETA_R: begin
        beta_q <= div_rsp_i.quot[15:0];
        dvd_q  <= 64'(rt_num);
        dvs_q  <= 64'(w);
        ret_q  <= ST_RT_R;
      end
      ST_RT_R: rtfac_q <= 18'd65536 + div_rsp_i.quot[17:0];
      ST_TR: tr_q <= tr_sum[49:16];
      ST_IT0: begin
        dvd_q <= 64'(it0_num);
        dvs_q <= 64'({den, 1'b0});
        ret_q <= ST_IT0_R;
      end
      ST_IT0_R: begin
        it0_q <= (div_rsp_i.quot < 64'd2) ? IW'(2) : IW'(div_rsp_i.quot);
        dvd_q <= 64'({tr_q, 1'b0}) + 64'(dt_eff);
        dvs_q <= 64'({dt_eff, 1'b0});
        ret_q <= ST_IT1_R;
      end
      ST_IT1_R: it1_q <= (div_rsp_i.quot < 64'd4) ? IW'(4) : IW'(div_rsp_i.quot);
      ST_IT2: begin
        it2_q <= it2_prod[IW+15:16];
        i_q   <= '0;
        nt_q  <= nt_eff;
      end
      ST_GEN: begin
        ret_q <= ST_GEN_R;
        if (in_rise) begin
          dvd_q <= (64'(i_q) << 31) + 64'(it0_q >> 1);
          dvs_q <= 64'(it0_q);
        end else if (in_fall) begin
          dvd_q <= (64'(iw - it0_q) << 31) + 64'(it0_q >> 1);
          dvs_q <= 64'(it0_q);
        end else begin
          dvd_q <= 64'(tail_prod) + 64'(d_tail >> 1);
          dvs_q <= 64'(d_tail);
        end
        if (i_q != nt_q && !in_rise && !in_fall && !in_tail) begin
          i_q <= i_q + 1'b1;
        end
      end
      ST_GEN_R: i_q <= i_q + 1'b1;
      ST_TRIM_INIT: n_q <= (nt_q == '0) ? '0 : nt_q - 1'b1;
      ST_TRIM_CHK: begin
        if (rd_q == 32'd0) begin
          n_q <= n_q - 1'b1;
        end
      end
      ST_TRIM_FIX: begin
        if (n_q != '0 && n_q < nt_q - 1'b1) begin
          n_q <= n_q + CW'(2);
        end
        i_q <= '0;
        s_q <= 48'd0;
      end
      ST_SUM_ACC: begin
        s_q <= s_q + 48'(rd_q);
        i_q <= i_q + 1'b1;
      end
      ST_SUM_DONE: begin
        i_q        <= '0;
        res_val_q  <= 32'd0;
        res_last_q <= 1'b1;
      end
      ST_F_SET: begin
        dvd_q <= {rd_q, 32'd0};
        dvs_q <= 64'(s_q);
        ret_q <= ST_F_R;
      end
      ST_F_R: f_q <= div_rsp_i.quot[32:0];
      ST_P: begin
        dvd_q <= slip_prod[63:0];
        dvs_q <= 64'(den);
        ret_q <= ST_Q_R;
      end
      ST_Q_R: begin
        res_val_q  <= (q_round > SampleLimit) ? SampleLimit[31:0] : q_round[31:0];
        res_last_q <= i_q == n_q - 1'b1;
      end
      ST_EMIT: begin
        if (can_load) begin
          i_q <= i_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // output register, lets the sequencer run ahead by one sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_EMIT && can_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_EMIT && can_load) begin
      out_value_q <= res_val_q;
      out_index_q <= 6'(i_q);
      out_len_q   <= 7'(n_q);
      out_last_q  <= res_last_q;
      if (n_q == '0 || s_q == 48'd0) begin
        out_index_q <= 6'd0;
        out_len_q   <= 7'd0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_index_o = out_index_q;
  assign out_len_o   = out_len_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

// File: rtl/two_triangle_slip_rate_core.sv
// ----------------------------------------------------------------------------
// two_triangle_slip_rate_core: slip-rate pulse generator
// per request: two-triangle shape with depth-blended tail, trimmed and scaled
// run time per request grows with nt (buffer length) and n (kept samples);
//   the shared one-bit-per-cycle divider sets most of it
// throughput: one request at a time in the sequencer, two more can queue
// reset: config registers take their defaults, queue and output register empty
// ----------------------------------------------------------------------------
`default_nettype none

module two_triangle_slip_rate_core #(
  parameter int unsigned MAX_SAMPLES = tts_pkg::MaxSamplesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request beats
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [79:0] s_axis_tdata,   // slip_amount, rise_time, source_depth
  // sample beats
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [47:0] m_axis_tdata,   // sample_value, sample_index, pulse_length
  output      logic        m_axis_tlast,   // last_sample
  // register writes
  input  wire logic        cfg_we_i,
  input  wire logic [tts_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [31:0] cfg_data_i
);
  import tts_pkg::*;

  cfg_t     cfg_q;
  req_t     q_item;
  logic     q_valid, q_pop;
  div_req_t div_req;
  div_rsp_t div_rsp;
  logic [31:0] out_value;
  logic [5:0]  out_index;
  logic [6:0]  out_len;

  // config registers, unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dt   <= RstDt;
      cfg_q.nt   <= RstNt;
      cfg_q.dmin <= RstDmin;
      cfg_q.dmax <= RstDmax;
      cfg_q.bd   <= RstBd;
      cfg_q.bs   <= RstBs;
      cfg_q.pf   <= RstPf;
      cfg_q.rs   <= RstRs;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_DT:   cfg_q.dt   <= cfg_data_i;
        CFG_NT:   cfg_q.nt   <= cfg_data_i[6:0];
        CFG_DMIN: cfg_q.dmin <= cfg_data_i[15:0];
        CFG_DMAX: cfg_q.dmax <= cfg_data_i[15:0];
        CFG_BD:   cfg_q.bd   <= cfg_data_i[15:0];
        CFG_BS:   cfg_q.bs   <= cfg_data_i[15:0];
        CFG_PF:   cfg_q.pf   <= cfg_data_i[15:0];
        CFG_RS:   cfg_q.rs   <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  // intake and depth classification
  tts_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (s_axis_tdata),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  // pulse build, trim, sum and scale
  tts_back #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_value_o (out_value),
    .out_index_o (out_index),
    .out_len_o   (out_len),
    .out_last_o  (m_axis_tlast)
  );

  // every division of the sequencer goes through this one unit
  tts_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign m_axis_tdata = {3'd0, out_len, out_index, out_value};

endmodule

`default_nettype wire

// File: tb/two_triangle_slip_rate_core_tb.sv
// ----------------------------------------------------------------------------
// two_triangle_slip_rate_core_tb: self-checking bench for the slip-rate core
// requests go in through a queue-fed driver and sample beats are checked
// against a bit-true pulse predictor, over several register settings
// ----------------------------------------------------------------------------
`default_nettype none

module two_triangle_slip_rate_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tts_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 4'd15;  // no register here

  typedef struct packed {
    logic [31:0] slip;
    logic [31:0] rise;
    logic [15:0] depth;
  } pulse_req_t;

  typedef struct packed {
    logic [31:0] value;
    logic [5:0]  index;
    logic [6:0]  length;
    logic        last;
  } sample_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [79:0] s_data = '0;   // slip_amount, rise_time, source_depth
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [47:0] m_data;        // sample_value, sample_index, pulse_length
  logic        m_last;        // last_sample
  logic        cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [31:0] cfg_data = '0;

  // requests still to send and sample beats still owed by the block
  pulse_req_t   req_q[$];
  sample_beat_t sample_q[$];
  pulse_req_t   req_on_bus;

  // shadow of the register file
  logic [31:0] sh_dt = RstDt;
  logic [6:0]  sh_nt = RstNt;
  logic [15:0] sh_dmin = RstDmin, sh_dmax = RstDmax;
  logic [15:0] sh_bd = RstBd, sh_bs = RstBs, sh_pf = RstPf;
  logic [16:0] sh_rs = RstRs;

  int unsigned cyc = 0;
  int unsigned n_reqs = 0;
  int unsigned n_beats = 0;
  int unsigned n_empty = 0;
  int unsigned n_phases = 0;
  int unsigned err_cnt = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  always #6 clk_i = ~clk_i;

  two_triangle_slip_rate_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tlast  (m_last),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data)
  );

  task automatic report_mismatch(input string what, input longint unsigned want,
                                 input longint unsigned got);
    $display("[%0t] mismatch on %s: expected %0d, got %0d (beat %0d)",
             $realtime, what, want, got, n_beats);
    err_cnt++;
  endtask

  // bit-true pulse model: shape, trim, sum, then scale every kept sample
  function automatic void predict_pulse(input pulse_req_t rq);
    logic [63:0] dt, nt, z, beta, rtfac, tr, den, it0, it1, it2;
    logic [63:0] n, s, w, v, b, d, f, p, q, r, i;
    logic [31:0] shp[64];
    sample_beat_t bt;
    dt = (sh_dt == 0) ? 64'd1 : 64'(sh_dt);
    nt = (sh_nt > 64) ? 64'd64 : 64'(sh_nt);
    z  = 64'(rq.depth);
    if (z >= sh_dmax) begin
      beta  = sh_bd;
      rtfac = 64'd65536;
    end else if (z > sh_dmin) begin
      // depth inside the blend band
      w     = 64'(sh_dmax) - 64'(sh_dmin);
      beta  = (64'(sh_bd) * (z - sh_dmin) + 64'(sh_bs) * (sh_dmax - z) + w / 2) / w;
      rtfac = 64'd65536 + (64'(sh_rs) * (sh_dmax - z) + w / 2) / w;
    end else begin
      beta  = sh_bs;
      rtfac = 64'd65536 + sh_rs;
    end
    tr  = (64'(rq.rise) * rtfac + 64'd32768) >> 16;
    den = dt << 16;
    it0 = (64'd2 * sh_pf * tr + den) / (64'd2 * den);
    if (it0 < 2) it0 = 2;
    it1 = (64'd2 * tr + dt) / (64'd2 * dt);
    if (it1 < 4) it1 = 4;
    it2 = ((64'd131072 - beta) * it0) >> 16;
    for (int k = 0; k < 64; k++) shp[k] = '0;
    for (i = 0; i < nt; i++) begin
      v = 0;
      if (i < it0) begin
        v = ((i << 31) + it0 / 2) / it0;
      end else if (i < it2) begin
        v = (64'd1 << 31) - ((((i - it0) << 31) + it0 / 2) / it0);
      end else if (i < it1) begin
        b = beta << 15;
        d = it1 - it2;
        v = b - (b * (i - it2) + d / 2) / d;
      end
      shp[i] = v[31:0];
    end
    // trim after the last nonzero sample, keeping one extra zero
    n = 0;
    if (nt >= 1) begin
      n = nt - 1;
      while (n > 0 && shp[n] == 0) n--;
      if (n > 0 && n < nt - 1) n += 2;
    end
    s = 0;
    for (i = 0; i < n; i++) s += shp[i];
    if (n == 0 || s == 0) begin
      bt = '{value: '0, index: '0, length: '0, last: 1'b1};
      sample_q.push_back(bt);
      n_empty++;
      return;
    end
    for (i = 0; i < n; i++) begin
      f = {shp[i], 32'd0} / s;
      p = 64'(rq.slip) * f;
      q = p / den;
      r = p % den;
      if (r >= den - r) q++;
      if (q > SampleLimit) q = SampleLimit;
      bt.value  = q[31:0];
      bt.index  = i[5:0];
      bt.length = n[6:0];
      bt.last   = (i == n - 1);
      sample_q.push_back(bt);
    end
  endfunction

  // idle-free window so long bursts happen on both sides
  function automatic bit calm_window();
    return (cyc % 16384) < 3000;
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
    end else begin
      cyc <= cyc + 1;
      if (!s_valid || s_ready) begin
        if (s_valid) begin
          predict_pulse(req_on_bus);
          n_reqs <= n_reqs + 1;
        end
        if (req_q.size() > 0 && (calm_window() || $urandom_range(99) >= 27)) begin
          req_on_bus = req_q.pop_front();
          s_data  <= {req_on_bus.depth, req_on_bus.rise, req_on_bus.slip};
          s_valid <= 1'b1;
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // sample monitor and receiver backpressure
  always @(posedge clk_i or negedge rst_ni) begin
    sample_beat_t want;
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      if (m_valid && m_ready) begin
        n_beats <= n_beats + 1;
        if (sample_q.size() == 0) begin
          report_mismatch("unexpected beat", 0, m_data[31:0]);
        end else begin
          want = sample_q.pop_front();
          if (m_data[31:0] !== want.value) report_mismatch("sample_value", want.value, m_data[31:0]);
          if (m_data[37:32] !== want.index) report_mismatch("sample_index", want.index, m_data[37:32]);
          if (m_data[44:38] !== want.length) report_mismatch("pulse_length", want.length, m_data[44:38]);
          if (m_data[47:45] !== 3'b000) report_mismatch("tdata padding", 0, m_data[47:45]);
          if (m_last !== want.last) report_mismatch("last_sample", want.last, m_last);
        end
      end
      // one long hold-off while the driver keeps offering requests
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_ready   <= 1'b0;
      end else if (!hold_done && n_reqs >= 40) begin
        hold_done <= 1'b1;
        hold_left <= 2500;
        m_ready   <= 1'b0;
      end else begin
        m_ready <= calm_window() || ($urandom_range(99) >= 27);
      end
    end
  end

  task automatic wait_drained();
    while (req_q.size() != 0 || s_valid || sample_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    case (idx)
      CFG_DT:   sh_dt   = val;
      CFG_NT:   sh_nt   = val[6:0];
      CFG_DMIN: sh_dmin = val[15:0];
      CFG_DMAX: sh_dmax = val[15:0];
      CFG_BD:   sh_bd   = val[15:0];
      CFG_BS:   sh_bs   = val[15:0];
      CFG_PF:   sh_pf   = val[15:0];
      CFG_RS:   sh_rs   = val[16:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic add_req(input logic [31:0] slip, rise, input logic [15:0] depth);
    req_q.push_back('{slip: slip, rise: rise, depth: depth});
  endtask

  // request whose rise time spans up to about twice the buffer, so shapes both fit and overrun it
  task automatic add_shaped_req();
    logic [31:0] rise;
    logic [15:0] depth;
    rise  = sh_dt * $urandom_range(1, 2 * ((sh_nt > 64) ? 64 : sh_nt) + 2)
            + $urandom_range(0, sh_dt);
    depth = ($urandom_range(3) == 0) ? 16'($urandom)
            : 16'($urandom_range(sh_dmin, sh_dmax) + $urandom_range(0, 64)
                  - $urandom_range(0, 64));
    add_req($urandom, rise, depth);
  endtask

  initial begin
    int nitems;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // defaults straight after reset
    n_phases++;
    add_req(32'h0001_0000, 32'h0000_8000, 16'd0);
    add_req(32'hFFFF_FFFF, 32'h0000_4000, 16'd1280);
    add_req(32'd0, 32'h0001_0000, 16'hFFFF);
    wait_drained();

    // short buffer, all depth regions and field extremes
    n_phases++;
    write_reg(CFG_NT, 32'd12);
    write_reg(CFG_RS, 32'd32768);
    add_req(32'h0000_0000, 32'h0000_0000, 16'd0);
    add_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    add_req(32'hFFFF_FFFF, 32'h0000_1800, 16'd1024);     // band lower edge
    add_req(32'h8000_0000, 32'h0000_1800, 16'd1536);     // band upper edge
    add_req(32'h0001_0000, 32'h0000_1800, 16'd1025);
    add_req(32'h0001_0000, 32'h0000_1800, 16'd1535);
    add_req(32'h0001_0000, 32'h0000_2000, 16'd1300);
    add_req(32'h0000_0001, 32'h0000_0400, 16'd0);        // tiny rise, minimum counts
    add_req(32'h5555_5555, 32'hAAAA_AAAA, 16'h5555);
    add_req(32'hAAAA_AAAA, 32'h5555_5555, 16'hAAAA);
    wait_drained();

    // zero-sum and empty-buffer pulses, zero interval
    n_phases++;
    write_reg(CFG_NT, 32'd1);
    add_req(32'h0001_0000, 32'h0000_1800, 16'd100);
    wait_drained();
    write_reg(CFG_NT, 32'd0);
    add_req(32'hFFFF_FFFF, 32'h0001_0000, 16'd2000);
    wait_drained();
    write_reg(CFG_NT, 32'd2);
    write_reg(CFG_DT, 32'd0);
    add_req(32'h0001_0000, 32'h0000_0008, 16'd100);
    add_req(32'h0001_0000, 32'h0000_0001, 16'd2000);
    wait_drained();

    // oversized buffer, inverted band, extreme ratios, spare register index
    n_phases++;
    write_reg(CFG_NT, 32'hFFFF_FFFF);
    write_reg(CFG_DT, 32'd1311);
    write_reg(CFG_DMIN, 32'd2000);
    write_reg(CFG_DMAX, 32'd1000);
    write_reg(CFG_BD, 32'd0);
    write_reg(CFG_BS, 32'hFFFF);
    write_reg(CFG_PF, 32'hFFFF);
    write_reg(CFG_RS, 32'h1_0000);
    write_reg(CfgIdxSpare, 32'hFFFF_FFFF);
    add_req(32'h0010_0000, 32'h0001_0000, 16'd1500);
    add_req(32'h0010_0000, 32'h0000_4000, 16'd999);
    add_req(32'h0010_0000, 32'h0000_4000, 16'd1000);
    wait_drained();

    // random phases, mostly short buffers, one long
    for (int ph = 0; ph < 8; ph++) begin
      n_phases++;
      write_reg(CFG_NT, (ph == 5) ? 32'd64 : $urandom_range(2, 14));
      write_reg(CFG_DT, (ph == 6) ? 32'hFFFF_FFFF : (ph == 2) ? 32'd1
                        : $urandom_range(1, 32'h0010_0000));
      write_reg(CFG_DMIN, $urandom_range(0, 4000));
      write_reg(CFG_DMAX, (ph == 3) ? 32'd0 : (ph == 4) ? 32'hFFFF
                          : sh_dmin + $urandom_range(1, 3000));
      write_reg(CFG_BD, (ph == 1) ? 32'hFFFF : $urandom_range(0, 65535));
      write_reg(CFG_BS, (ph == 1) ? 32'd0 : $urandom_range(0, 65535));
      write_reg(CFG_PF, (ph == 7) ? 32'd0 : $urandom_range(0, 65535));
      write_reg(CFG_RS, (ph == 7) ? 32'h1_0000 : $urandom_range(0, 65536));
      nitems = (ph == 5) ? 6 : 24;
      for (int k = 0; k < nitems; k++) begin
        if ($urandom_range(9) < 8) add_shaped_req();
        else add_req($urandom, $urandom, 16'($urandom));
      end
      wait_drained();
    end

    repeat (200) @(posedge clk_i);
    $display("covered %0d requests in %0d register settings, %0d sample beats,",
             n_reqs, n_phases, n_beats);
    $display("%0d empty pulses, long receiver hold-off done: %0d", n_empty, hold_done);
    if (err_cnt == 0 && sample_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("timeout with %0d beats still owed", sample_q.size());
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire

// File: two_triangle_slip_rate_core.f
rtl/tts_pkg.sv
rtl/tts_div.sv
rtl/tts_front.sv
rtl/tts_back.sv
rtl/two_triangle_slip_rate_core.sv
tb/two_triangle_slip_rate_core_tb.sv
